// ===== hw/rtl/yuv2rgb_pkg.sv =====
`timescale 1ns / 1ps

package yuv2rgb_pkg;

   localparam int COEF_FRAC_BITS_DEFAULT = 12;
   // integer bits above the fraction in every signed sum, sign included
   localparam int SUM_INT_BITS = 12;

   localparam int PIX_W       = 8;
   localparam int REQ_DATA_W  = 4 * PIX_W;
   localparam int RSP_DATA_W  = 6 * PIX_W;
   localparam int CHROMA_BIAS = 128;

   localparam logic MODE_FULL   = 1'b0;
   localparam logic MODE_STUDIO = 1'b1;

   // matrix constants, scaled by 10000
   localparam longint K_FR_RV_X10K = 14075;
   localparam longint K_FR_GU_X10K = 3455;
   localparam longint K_FR_GV_X10K = 7169;
   localparam longint K_FR_BU_X10K = 17790;
   localparam longint K_SR_Y_X10K  = 11640;
   localparam longint K_SR_RV_X10K = 15960;
   localparam longint K_SR_GU_X10K = 3910;
   localparam longint K_SR_GV_X10K = 8130;
   localparam longint K_SR_BU_X10K = 20180;
   localparam longint K_SR_RO_X10K = 2229120;
   localparam longint K_SR_GO_X10K = 1354880;
   localparam longint K_SR_BO_X10K = 2769280;

   // round to nearest, halves up, at frac fraction bits
   function automatic longint fix_coef(input longint x10k, input int frac);
      return (x10k * (longint'(1) << frac) + 64'sd5000) / 64'sd10000;
   endfunction

endpackage

// ===== hw/rtl/yuv2rgb_mul.sv =====
`timescale 1ns / 1ps

module yuv2rgb_mul #(
   parameter int COEF_FRAC_BITS = yuv2rgb_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic mode,
   input  logic in_valid,
   output logic in_ready,
   input  logic [yuv2rgb_pkg::PIX_W-1:0] luma_first,
   input  logic [yuv2rgb_pkg::PIX_W-1:0] luma_second,
   input  logic [yuv2rgb_pkg::PIX_W-1:0] chroma_blue,
   input  logic [yuv2rgb_pkg::PIX_W-1:0] chroma_red,
   input  logic frame_end,
   output logic out_valid,
   input  logic out_ready,
   output logic out_mode,
   output logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] ys0,
   output logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] ys1,
   output logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] prv,
   output logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] pgu,
   output logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] pgv,
   output logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] pbu,
   output logic out_frame_end
);
   import yuv2rgb_pkg::*;

   localparam int SumW = COEF_FRAC_BITS + SUM_INT_BITS;
   localparam int ExtW = SumW - PIX_W;

   localparam logic signed [SumW-1:0] KOne  = SumW'(longint'(1) << COEF_FRAC_BITS);
   localparam logic signed [SumW-1:0] KFrRv = SumW'(fix_coef(K_FR_RV_X10K, COEF_FRAC_BITS));
   localparam logic signed [SumW-1:0] KFrGu = SumW'(fix_coef(K_FR_GU_X10K, COEF_FRAC_BITS));
   localparam logic signed [SumW-1:0] KFrGv = SumW'(fix_coef(K_FR_GV_X10K, COEF_FRAC_BITS));
   localparam logic signed [SumW-1:0] KFrBu = SumW'(fix_coef(K_FR_BU_X10K, COEF_FRAC_BITS));
   localparam logic signed [SumW-1:0] KSrY  = SumW'(fix_coef(K_SR_Y_X10K, COEF_FRAC_BITS));
   localparam logic signed [SumW-1:0] KSrRv = SumW'(fix_coef(K_SR_RV_X10K, COEF_FRAC_BITS));
   localparam logic signed [SumW-1:0] KSrGu = SumW'(fix_coef(K_SR_GU_X10K, COEF_FRAC_BITS));
   localparam logic signed [SumW-1:0] KSrGv = SumW'(fix_coef(K_SR_GV_X10K, COEF_FRAC_BITS));
   localparam logic signed [SumW-1:0] KSrBu = SumW'(fix_coef(K_SR_BU_X10K, COEF_FRAC_BITS));
   localparam logic signed [SumW-1:0] Bias  = SumW'(CHROMA_BIAS);

   logic studio;
   logic signed [SumW-1:0] k_y, k_rv, k_gu, k_gv, k_bu;
   logic signed [SumW-1:0] y0_ext, y1_ext, cu, cv, chroma_off;
   logic signed [SumW-1:0] ys0_in, ys1_in, prv_in, pgu_in, pgv_in, pbu_in;
   logic signed [SumW-1:0] ys0_ff, ys1_ff, prv_ff, pgu_ff, pgv_ff, pbu_ff;
   logic valid_ff, mode_ff, frame_end_ff;

   assign studio = (mode == MODE_STUDIO);

   always_comb begin
      k_y  = studio ? KSrY  : KOne;
      k_rv = studio ? KSrRv : KFrRv;
      k_gu = studio ? KSrGu : KFrGu;
      k_gv = studio ? KSrGv : KFrGv;
      k_bu = studio ? KSrBu : KFrBu;
      chroma_off = studio ? '0 : Bias;
      y0_ext = $signed({{ExtW{1'b0}}, luma_first});
      y1_ext = $signed({{ExtW{1'b0}}, luma_second});
      cu     = $signed({{ExtW{1'b0}}, chroma_blue}) - chroma_off;
      cv     = $signed({{ExtW{1'b0}}, chroma_red}) - chroma_off;
      ys0_in = k_y * y0_ext;
      ys1_in = k_y * y1_ext;
      prv_in = k_rv * cv;
      pgu_in = k_gu * cu;
      pgv_in = k_gv * cv;
      pbu_in = k_bu * cu;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ys0_ff       <= ys0_in;
         ys1_ff       <= ys1_in;
         prv_ff       <= prv_in;
         pgu_ff       <= pgu_in;
         pgv_ff       <= pgv_in;
         pbu_ff       <= pbu_in;
         mode_ff      <= mode;
         frame_end_ff <= frame_end;
      end
   end

   assign out_valid     = valid_ff;
   assign out_mode      = mode_ff;
   assign ys0           = ys0_ff;
   assign ys1           = ys1_ff;
   assign prv           = prv_ff;
   assign pgu           = pgu_ff;
   assign pgv           = pgv_ff;
   assign pbu           = pbu_ff;
   assign out_frame_end = frame_end_ff;

endmodule

// ===== hw/rtl/yuv2rgb_sum.sv =====
`timescale 1ns / 1ps

module yuv2rgb_sum #(
   parameter int COEF_FRAC_BITS = yuv2rgb_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic mode,
   input  logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] ys0,
   input  logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] ys1,
   input  logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] prv,
   input  logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] pgu,
   input  logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] pgv,
   input  logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] pbu,
   input  logic frame_end,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] out_ys0,
   output logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] out_ys1,
   output logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] chr_r,
   output logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] chr_g,
   output logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] chr_b,
   output logic out_frame_end
);
   import yuv2rgb_pkg::*;

   localparam int SumW = COEF_FRAC_BITS + SUM_INT_BITS;

   localparam logic signed [SumW-1:0] KSrRo = SumW'(fix_coef(K_SR_RO_X10K, COEF_FRAC_BITS));
   localparam logic signed [SumW-1:0] KSrGo = SumW'(fix_coef(K_SR_GO_X10K, COEF_FRAC_BITS));
   localparam logic signed [SumW-1:0] KSrBo = SumW'(fix_coef(K_SR_BO_X10K, COEF_FRAC_BITS));

   logic signed [SumW-1:0] off_r, off_g, off_b;
   logic signed [SumW-1:0] chr_r_in, chr_g_in, chr_b_in;
   logic signed [SumW-1:0] chr_r_ff, chr_g_ff, chr_b_ff, ys0_ff, ys1_ff;
   logic valid_ff, frame_end_ff;

   // chroma terms and offsets are shared by both pixels
   always_comb begin
      off_r    = (mode == MODE_STUDIO) ? KSrRo : '0;
      off_g    = (mode == MODE_STUDIO) ? KSrGo : '0;
      off_b    = (mode == MODE_STUDIO) ? KSrBo : '0;
      chr_r_in = prv - off_r;
      chr_g_in = off_g - pgu - pgv;
      chr_b_in = pbu - off_b;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ys0_ff       <= ys0;
         ys1_ff       <= ys1;
         chr_r_ff     <= chr_r_in;
         chr_g_ff     <= chr_g_in;
         chr_b_ff     <= chr_b_in;
         frame_end_ff <= frame_end;
      end
   end

   assign out_valid     = valid_ff;
   assign out_ys0       = ys0_ff;
   assign out_ys1       = ys1_ff;
   assign chr_r         = chr_r_ff;
   assign chr_g         = chr_g_ff;
   assign chr_b         = chr_b_ff;
   assign out_frame_end = frame_end_ff;

endmodule

// ===== hw/rtl/yuv2rgb_sat.sv =====
`timescale 1ns / 1ps

module yuv2rgb_sat #(
   parameter int COEF_FRAC_BITS = yuv2rgb_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] ys0,
   input  logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] ys1,
   input  logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] chr_r,
   input  logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] chr_g,
   input  logic signed [COEF_FRAC_BITS+yuv2rgb_pkg::SUM_INT_BITS-1:0] chr_b,
   input  logic frame_end,
   output logic out_valid,
   input  logic out_ready,
   output logic [yuv2rgb_pkg::RSP_DATA_W-1:0] rgb_pair,
   output logic out_frame_end
);
   import yuv2rgb_pkg::*;

   localparam int SumW = COEF_FRAC_BITS + SUM_INT_BITS;

   logic signed [SumW-1:0] r0, g0, b0, r1, g1, b1;
   logic [RSP_DATA_W-1:0] rgb_in, rgb_ff;
   logic valid_ff, frame_end_ff;

   // floor, then clamp to 0..255
   function automatic logic [PIX_W-1:0] sat8(input logic signed [SumW-1:0] s);
      logic [PIX_W-1:0] v;
      if (s[SumW-1]) begin
         v = '0;
      end else if (|s[SumW-2:COEF_FRAC_BITS+PIX_W]) begin
         v = '1;
      end else begin
         v = s[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
      end
      return v;
   endfunction

   always_comb begin
      r0 = ys0 + chr_r;
      g0 = ys0 + chr_g;
      b0 = ys0 + chr_b;
      r1 = ys1 + chr_r;
      g1 = ys1 + chr_g;
      b1 = ys1 + chr_b;
      rgb_in = {sat8(b1), sat8(g1), sat8(r1), sat8(b0), sat8(g0), sat8(r0)};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rgb_ff       <= rgb_in;
         frame_end_ff <= frame_end;
      end
   end

   assign out_valid     = valid_ff;
   assign rgb_pair      = rgb_ff;
   assign out_frame_end = frame_end_ff;

endmodule

// ===== hw/rtl/yuyv422_to_rgb888.sv =====
`timescale 1ns / 1ps
// An accepted req item reaches rsp_tvalid through the multiply, chroma-sum and
// add/saturate register stages.
// Throughput: one macropixel (two RGB888 pixels) per cycle; each stage holds its item
// under back-pressure, so the pipeline stalls only while rsp_tready stays low.
// Reset (synchronous, active high) empties the pipeline and sets matrix_mode to 0.

module yuyv422_to_rgb888 #(
   parameter int COEF_FRAC_BITS = yuv2rgb_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_data,                                 // matrix_mode
   input  logic req_tvalid,
   output logic req_tready,
   // luma_first, luma_second, chroma_blue, chroma_red
   input  logic [yuv2rgb_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic req_tlast,                                // frame_end_in
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // red_first, green_first, blue_first, red_second, green_second, blue_second
   output logic [yuv2rgb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic rsp_tlast                                 // frame_end_out
);
   import yuv2rgb_pkg::*;

   localparam int SumW = COEF_FRAC_BITS + SUM_INT_BITS;

   logic mode_ff;
   logic s1_valid, s1_ready, s1_mode, s1_last;
   logic s2_valid, s2_ready, s2_last;
   logic signed [SumW-1:0] s1_ys0, s1_ys1, s1_prv, s1_pgu, s1_pgv, s1_pbu;
   logic signed [SumW-1:0] s2_ys0, s2_ys1, s2_cr, s2_cg, s2_cb;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FULL;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   yuv2rgb_mul #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mul (
      .clock        (clock),
      .reset        (reset),
      .mode         (mode_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .luma_first   (req_tdata[PIX_W-1:0]),
      .luma_second  (req_tdata[2*PIX_W-1:PIX_W]),
      .chroma_blue  (req_tdata[3*PIX_W-1:2*PIX_W]),
      .chroma_red   (req_tdata[4*PIX_W-1:3*PIX_W]),
      .frame_end    (req_tlast),
      .out_valid    (s1_valid),
      .out_ready    (s1_ready),
      .out_mode     (s1_mode),
      .ys0          (s1_ys0),
      .ys1          (s1_ys1),
      .prv          (s1_prv),
      .pgu          (s1_pgu),
      .pgv          (s1_pgv),
      .pbu          (s1_pbu),
      .out_frame_end(s1_last)
   );

   yuv2rgb_sum #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sum (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid),
      .in_ready     (s1_ready),
      .mode         (s1_mode),
      .ys0          (s1_ys0),
      .ys1          (s1_ys1),
      .prv          (s1_prv),
      .pgu          (s1_pgu),
      .pgv          (s1_pgv),
      .pbu          (s1_pbu),
      .frame_end    (s1_last),
      .out_valid    (s2_valid),
      .out_ready    (s2_ready),
      .out_ys0      (s2_ys0),
      .out_ys1      (s2_ys1),
      .chr_r        (s2_cr),
      .chr_g        (s2_cg),
      .chr_b        (s2_cb),
      .out_frame_end(s2_last)
   );

   yuv2rgb_sat #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sat (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s2_valid),
      .in_ready     (s2_ready),
      .ys0          (s2_ys0),
      .ys1          (s2_ys1),
      .chr_r        (s2_cr),
      .chr_g        (s2_cg),
      .chr_b        (s2_cb),
      .frame_end    (s2_last),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .rgb_pair     (rsp_tdata),
      .out_frame_end(rsp_tlast)
   );

endmodule

// ===== tb/yuyv422_checker.sv =====
`timescale 1ns / 1ps

module yuyv422_checker #(
   parameter int FRAC = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic csr_data,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [yuv2rgb_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic req_tlast,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [yuv2rgb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic rsp_tlast,
   output int   error_count,
   output int   pending_pairs,
   output int   pairs_checked
);
   import yuv2rgb_pkg::*;

   typedef struct {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
      logic       frame_end;
   } rgb_pair_type;

   // decimal constant given times 10^4, rounded to FRAC fraction bits, halves up
   function automatic longint to_fixed(input longint tenk);
      longint scaled;
      scaled = tenk * (longint'(1) << FRAC);
      return (scaled + 64'sd5000) / 64'sd10000;
   endfunction

   localparam longint FULL_RV   = to_fixed(14075);
   localparam longint FULL_GU   = to_fixed(3455);
   localparam longint FULL_GV   = to_fixed(7169);
   localparam longint FULL_BU   = to_fixed(17790);
   localparam longint STUDIO_Y  = to_fixed(11640);
   localparam longint STUDIO_RV = to_fixed(15960);
   localparam longint STUDIO_GU = to_fixed(3910);
   localparam longint STUDIO_GV = to_fixed(8130);
   localparam longint STUDIO_BU = to_fixed(20180);
   localparam longint STUDIO_RO = to_fixed(2229120);
   localparam longint STUDIO_GO = to_fixed(1354880);
   localparam longint STUDIO_BO = to_fixed(2769280);

   rgb_pair_type expected_pairs[$];
   logic         matrix_mode;

   function automatic logic [7:0] floor_clamp(input longint acc);
      longint whole;
      if (acc < 0) return 8'd0;
      whole = acc >>> FRAC;
      return (whole > 255) ? 8'd255 : whole[7:0];
   endfunction

   // returns {blue, green, red}
   function automatic logic [23:0] pixel_rgb(input logic m, input logic [7:0] y,
                                             input logic [7:0] u, input logic [7:0] v);
      longint yl, ul, vl, ys, r, g, b;
      yl = longint'(y);
      ul = longint'(u);
      vl = longint'(v);
      if (m == MODE_STUDIO) begin
         ys = STUDIO_Y * yl;
         r  = ys + STUDIO_RV * vl - STUDIO_RO;
         g  = ys - STUDIO_GU * ul - STUDIO_GV * vl + STUDIO_GO;
         b  = ys + STUDIO_BU * ul - STUDIO_BO;
      end else begin
         ys = yl <<< FRAC;
         ul = ul - CHROMA_BIAS;
         vl = vl - CHROMA_BIAS;
         r  = ys + FULL_RV * vl;
         g  = ys - FULL_GU * ul - FULL_GV * vl;
         b  = ys + FULL_BU * ul;
      end
      return {floor_clamp(b), floor_clamp(g), floor_clamp(r)};
   endfunction

   function automatic rgb_pair_type convert_pair(input logic m,
                                                 input logic [REQ_DATA_W-1:0] d,
                                                 input logic eof);
      rgb_pair_type p;
      logic [23:0]  px;
      px = pixel_rgb(m, d[7:0], d[23:16], d[31:24]);
      {p.blue_first, p.green_first, p.red_first} = px;
      px = pixel_rgb(m, d[15:8], d[23:16], d[31:24]);
      {p.blue_second, p.green_second, p.red_second} = px;
      p.frame_end = eof;
      return p;
   endfunction

   task automatic check_channel(input string what, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      rgb_pair_type want;
      if (reset) begin
         matrix_mode = MODE_FULL;
         expected_pairs.delete();
         error_count   = 0;
         pairs_checked = 0;
      end else begin
         if (csr_valid && csr_ready) matrix_mode = csr_data;
         if (req_tvalid && req_tready)
            expected_pairs.push_back(convert_pair(matrix_mode, req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pairs.size() == 0) begin
               error_count++;
               $display("%0t: unexpected rsp item, expected none actual %h/%b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_pairs.pop_front();
               check_channel("red_first",    want.red_first,    rsp_tdata[7:0]);
               check_channel("green_first",  want.green_first,  rsp_tdata[15:8]);
               check_channel("blue_first",   want.blue_first,   rsp_tdata[23:16]);
               check_channel("red_second",   want.red_second,   rsp_tdata[31:24]);
               check_channel("green_second", want.green_second, rsp_tdata[39:32]);
               check_channel("blue_second",  want.blue_second,  rsp_tdata[47:40]);
               check_channel("frame_end",    {7'd0, want.frame_end}, {7'd0, rsp_tlast});
               pairs_checked++;
            end
         end
      end
      // nonblocking so the stimulus side sees the count as of the previous edge
      pending_pairs <= expected_pairs.size();
   end

endmodule

// ===== tb/tb_yuyv422_to_rgb888.sv =====
`timescale 1ns / 1ps

module tb_yuyv422_to_rgb888;
   import yuv2rgb_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_TAIL      = 8;
   localparam int NUM_PHASES      = 6;
   localparam int PAIRS_PER_PHASE = 240;
   localparam int CALM_PHASE      = 3;
   localparam int IDLE_PCT        = 19;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_data = MODE_FULL;
   logic req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tready = 1'b0;
   logic csr_ready;
   logic req_tready;
   logic rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   int idle_pct = IDLE_PCT;
   int error_count;
   int pending_pairs;
   int pairs_checked;
   int pairs_sent = 0;
   int frames_sent = 0;
   int mode_writes = 0;
   int quiet_cycles = 0;

   yuyv422_to_rgb888 dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   yuyv422_checker #(.FRAC(COEF_FRAC_BITS_DEFAULT)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .pending_pairs (pending_pairs),
      .pairs_checked (pairs_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d items outstanding",
                  $time, quiet_cycles, pending_pairs);
         $display("yuyv422_to_rgb888 test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // mostly uniform, with extra weight on the range ends and the chroma midpoint
   function automatic logic [7:0] pick_sample();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd128;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_pair(input logic [7:0] y0, input logic [7:0] y1,
                            input logic [7:0] u, input logic [7:0] v, input logic eof);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v, u, y1, y0};
      req_tlast  <= eof;
      do @(posedge clock); while (!req_tready);
      pairs_sent++;
      if (eof) frames_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pairs != 0) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_writes++;
   endtask

   task automatic run_directed();
      send_pair(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
      send_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_pair(8'd0,   8'd255, 8'd128, 8'd128, 1'b0);
      send_pair(8'd255, 8'd0,   8'd128, 8'd128, 1'b0);
      send_pair(8'd128, 8'd128, 8'd0,   8'd255, 1'b0);
      send_pair(8'd128, 8'd128, 8'd255, 8'd0,   1'b0);
      send_pair(8'd16,  8'd235, 8'd128, 8'd128, 1'b0);
      send_pair(8'd0,   8'd255, 8'd0,   8'd0,   1'b0);
      send_pair(8'd255, 8'd0,   8'd255, 8'd255, 1'b0);
      send_pair(8'd235, 8'd16,  8'd240, 8'd16,  1'b1);
   endtask

   // frames of random length; about one in ten carries a scrambled end mark
   task automatic run_frames(input int count);
      int done;
      int len;
      bit scrambled;
      logic eof;
      done = 0;
      while (done < count) begin
         len = $urandom_range(32, 1);
         if (len > count - done) len = count - done;
         scrambled = ($urandom_range(9) == 0);
         for (int k = 0; k < len; k++) begin
            eof = scrambled ? 1'($urandom_range(1)) : (k == len - 1);
            send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(), eof);
            done++;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_mode(MODE_FULL);
      run_directed();
      write_mode(MODE_STUDIO);
      run_directed();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_mode((p % 2 == 1) ? MODE_STUDIO : MODE_FULL);
         idle_pct = (p == CALM_PHASE) ? 0 : IDLE_PCT;
         run_frames(PAIRS_PER_PHASE);
      end
      idle_pct = IDLE_PCT;

      drain();
      repeat (DRAIN_TAIL) @(posedge clock);

      $display("Converted %0d macropixels (%0d frame ends) over %0d matrix mode writes,",
               pairs_sent, frames_sent, mode_writes);
      $display("both matrices, field extremes and random stalls; %0d pairs compared.",
               pairs_checked);
      if (error_count == 0) begin
         $display("yuyv422_to_rgb888 test passed");
      end else begin
         $display("%0d errors", error_count);
         $display("yuyv422_to_rgb888 test failed");
      end
      $finish;
   end

endmodule
